// ===== rtl/core/fhpa_pkg.sv =====
// Shared constants and types for the handle pool allocator.
`default_nettype none

package fhpa_pkg;

   localparam int DEF_POOL_SIZE = 256;
   localparam int HANDLE_W      = 8;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 2;

   localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TRY     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NONE      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request fields, launch free queue read
      logic execute;   // update pool state, load result register
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/fhpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fhpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/fhpa_ctrl.sv =====
// Sequencing state machine: accept, execute, hold result until taken.
`default_nettype none

module fhpa_ctrl
   import fhpa_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output dp_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEND
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.execute = (state_ff == ST_EXEC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_SEND;
               rsp_valid_ff <= 1'b1;
            end
            ST_SEND: begin
               if (!rsp_stall) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_stall_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fhpa_dp.sv =====
// Datapath: in-use bitmap, free queue pointers, fresh counter, result register.
`default_nettype none

module fhpa_dp
   import fhpa_pkg::*;
#(
   parameter int POOL_SIZE = DEF_POOL_SIZE
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [HANDLE_W-1:0] req_handle,
   output logic      [HANDLE_W-1:0] rsp_granted_handle,
   output logic      [STATUS_W-1:0] rsp_status
);

   // Only handles below 2**HANDLE_W can be released, so bitmap and queue
   // never need more entries than that.
   localparam int MAP_DEPTH = (POOL_SIZE < (1 << HANDLE_W)) ? POOL_SIZE : (1 << HANDLE_W);
   localparam int PTR_W     = $clog2(MAP_DEPTH);
   localparam int CNT_W     = $clog2(MAP_DEPTH + 1);
   localparam int FRESH_W   = $clog2(POOL_SIZE + 1);

   logic [MODE_W-1:0]   mode_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [MAP_DEPTH-1:0] in_use_ff, in_use_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [FRESH_W-1:0]  fresh_ff, fresh_in;
   logic [HANDLE_W-1:0] granted_ff, granted_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                ram_wr_en;
   logic [PTR_W-1:0]    ram_rd_data;
   logic [PTR_W-1:0]    rel_idx;
   logic                rel_ok;
   logic                have_queued;

   fhpa_ram #(
      .WIDTH (PTR_W),
      .DEPTH (MAP_DEPTH)
   ) u_free_queue (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (rel_idx),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // queue head entry is read at the capture edge, used during execute
   always_comb begin
      in_use_in   = in_use_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      fresh_in    = fresh_ff;
      granted_in  = granted_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      have_queued = (count_ff != '0);
      rel_idx     = handle_ff[PTR_W-1:0];
      rel_ok      = ((HANDLE_W + 1)'(handle_ff) < (HANDLE_W + 1)'(MAP_DEPTH))
                    && in_use_ff[rel_idx];

      if (cmd.execute) begin
         granted_in = '0;
         status_in  = ST_OK;
         unique case (mode_ff)
            MODE_ALLOC, MODE_TRY: begin
               if (have_queued) begin
                  granted_in             = HANDLE_W'(ram_rd_data);
                  in_use_in[ram_rd_data] = 1'b1;
                  head_in  = (head_ff == PTR_W'(MAP_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                  count_in = count_ff - 1'b1;
               end else if (mode_ff == MODE_TRY) begin
                  status_in = ST_NONE;
               end else if (fresh_ff < FRESH_W'(POOL_SIZE)) begin
                  granted_in = HANDLE_W'(fresh_ff);
                  fresh_in   = fresh_ff + 1'b1;
                  if (fresh_ff < FRESH_W'(MAP_DEPTH)) begin
                     in_use_in[fresh_ff[PTR_W-1:0]] = 1'b1;
                  end
               end else begin
                  status_in = ST_EXHAUSTED;
               end
            end
            MODE_RELEASE: begin
               if (rel_ok) begin
                  in_use_in[rel_idx] = 1'b0;
                  ram_wr_en = 1'b1;
                  tail_in   = (tail_ff == PTR_W'(MAP_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                  count_in  = count_ff + 1'b1;
               end else begin
                  status_in = ST_INVALID;
               end
            end
            default: begin
               // unused mode: no state change, ok with zero handle
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         handle_ff <= req_handle;
      end
      granted_ff <= granted_in;
      status_ff  <= status_in;
      if (reset) begin
         in_use_ff <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         fresh_ff  <= '0;
      end else begin
         in_use_ff <= in_use_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         fresh_ff  <= fresh_in;
      end
   end

   assign rsp_granted_handle = granted_ff;
   assign rsp_status         = status_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fifo_handle_pool_allocator_unit.sv =====
// Handle pool allocator with FIFO reuse of released handles.
//
// Request channel (req_*): mode is allocate, try-allocate or release; handle
// names the handle to release. Result channel (rsp_*): granted_handle and
// status, exactly one result item per request item.
// Allocate reuses the oldest released handle, else issues the next never-used
// handle, else reports exhaustion. Try-allocate only reuses released handles.
// Release of a handle not in use is reported invalid and changes nothing.
// Sequence: an accepted item goes to the execute step, which loads the
// result register; the result is then offered on rsp_*. The unit works on
// one item at a time, so req_stall stays high from acceptance until the
// result is taken. The free queue RAM read (one registered read of the
// queue head) is why execute is a step of its own after acceptance.
// While rsp_stall is high the result and rsp_valid hold and no new item is
// accepted. Synchronous reset clears the in-use bitmap, queue pointers and
// fresh counter.
`default_nettype none

module fifo_handle_pool_allocator_unit
   import fhpa_pkg::*;
#(
   parameter int POOL_SIZE = DEF_POOL_SIZE
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [HANDLE_W-1:0] req_handle,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [HANDLE_W-1:0] rsp_granted_handle,
   output logic      [STATUS_W-1:0] rsp_status
);

   dp_cmd_type cmd;

   fhpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   fhpa_dp #(
      .POOL_SIZE (POOL_SIZE)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_mode           (req_mode),
      .req_handle         (req_handle),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/core/fhpa_checker.sv =====
// Port-level checks for the allocator, bound to the top level.
`default_nettype none

module fhpa_checker
   import fhpa_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [HANDLE_W-1:0] rsp_granted_handle,
   input wire logic [STATUS_W-1:0] rsp_status
);

   // one item in flight: after an accept, input is held off
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another is in flight");

   // no new item while a result is waiting
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request channel open while result pending");

   // failed requests carry no handle
   a_fail_zero_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_granted_handle == '0)
      else $error("nonzero handle on failed request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_granted_handle)
                                 && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind fifo_handle_pool_allocator_unit fhpa_checker u_fhpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_granted_handle (rsp_granted_handle),
   .rsp_status         (rsp_status)
);

`default_nettype wire
